// ----- rtl/core/ihds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihds_pkg
// Types and constants for the image header dimension sniffer.
// ----------------------------------------------------------------------------
package ihds_pkg;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_GIF  = 3'd1,
        FMT_JPEG = 3'd2,
        FMT_PNG  = 3'd3,
        FMT_BMP  = 3'd4,
        FMT_TIFF = 3'd5
    } fmt_t;

    typedef enum logic [4:0] {
        PH_MAGIC     = 5'd0,
        PH_FAIL      = 5'd1,
        PH_GIF_W     = 5'd2,
        PH_GIF_H     = 5'd3,
        PH_PNG_W     = 5'd4,
        PH_PNG_H     = 5'd5,
        PH_BMP_W     = 5'd6,
        PH_BMP_H     = 5'd7,
        PH_JP_MARK   = 5'd8,
        PH_JP_LEN    = 5'd9,
        PH_JP_H      = 5'd10,
        PH_JP_W      = 5'd11,
        PH_JP_PREFIX = 5'd12,
        PH_TF_IFD    = 5'd13,
        PH_TF_COUNT  = 5'd14,
        PH_TF_TAG    = 5'd15,
        PH_TF_TYPE   = 5'd16,
        PH_TF_VAL    = 5'd17
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_file;
    } in_t;

    typedef struct packed {
        fmt_t        format;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } out_t;

    localparam logic [7:0]  CH_G          = 8'h47;
    localparam logic [7:0]  CH_I          = 8'h49;
    localparam logic [7:0]  CH_F          = 8'h46;
    localparam logic [7:0]  CH_B          = 8'h42;
    localparam logic [7:0]  CH_M          = 8'h4D;
    localparam logic [7:0]  PNG_SIG0      = 8'd137;
    localparam logic [7:0]  CH_P          = 8'h50;
    localparam logic [7:0]  CH_N          = 8'h4E;
    localparam logic [7:0]  JPEG_PREFIX   = 8'hFF;
    localparam logic [7:0]  JPEG_SOI      = 8'hD8;
    localparam logic [15:0] JPEG_SOF0     = 16'd192;
    localparam logic [15:0] JPEG_SOF1     = 16'd193;
    localparam logic [15:0] JPEG_SOF2     = 16'd194;
    localparam logic [31:0] TIFF_MAGIC_BE = 32'h4D4D002A;
    localparam logic [31:0] TIFF_MAGIC_LE = 32'h49492A00;
    localparam logic [15:0] TIFF_TAG_W    = 16'd256;
    localparam logic [15:0] TIFF_TAG_H    = 16'd257;
    localparam logic [15:0] TIFF_SHORT    = 16'd3;
    localparam logic [15:0] TIFF_SSHORT   = 16'd8;
    localparam int          TIFF_HDR_LEN  = 8;
    // Bytes from the end of the signature to the first dimension field.
    localparam int          GIF_PAD       = 3;
    localparam int          PNG_BMP_PAD   = 15;

endpackage

// ----- rtl/core/image_header_dimension_sniffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_dimension_sniffer
// Detects GIF, JPEG, PNG, BMP and TIFF from a byte stream and reports the
// image width and height found in the header.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | ihds_pkg::in_t  (one file byte)
//  m_      | out       | m_valid / m_ready  | ihds_pkg::out_t (format, size)
//
// Every byte is parsed in the cycle it is accepted; one byte per cycle while s_ready is high.
// At most one result per file, loaded into the output register on the
// byte that completes both dimensions or on the end-of-file byte.
// s_ready drops only while a result waits in the output register and
// m_ready is low. A start-of-file byte clears the parse state first.
// aresetn is synchronous and active low.
// ----------------------------------------------------------------------------
module image_header_dimension_sniffer #(
    parameter int OFFSET_BITS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ihds_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ihds_pkg::out_t  m_data
);

    ihds_pkg::phase_t       phase_reg, phase_next, cur_phase;
    logic [31:0]            magic_reg, magic_next, cur_magic;
    logic [OFFSET_BITS-1:0] skip_reg, skip_next, cur_skip;
    logic [31:0]            accum_reg, accum_next, cur_accum;
    logic [2:0]             fbi_reg, fbi_next, cur_fbi;
    logic                   be_reg, be_next, cur_be;
    logic [15:0]            left_reg, left_next, cur_left;
    logic [15:0]            tag_reg, tag_next, cur_tag;
    logic                   short_reg, short_next, cur_short;
    logic [31:0]            width_reg, width_next, cur_width;
    logic [31:0]            height_reg, height_next, cur_height;
    logic                   wknown_reg, wknown_next, cur_wknown;
    logic                   hknown_reg, hknown_next, cur_hknown;
    logic                   done_reg, done_next, cur_done;

    logic                   m_valid_reg;
    ihds_pkg::out_t         m_data_reg;

    logic                   in_fire;
    logic                   emit;
    ihds_pkg::out_t         emit_data;

    logic [7:0]             b;
    logic [31:0]            acc_base, acc_take;
    logic [2:0]             fbi_inc;
    logic                   got2, got4, got_val, val_short;
    logic [15:0]            left_dec;
    logic [OFFSET_BITS-1:0] ifd;
    logic [15:0]            seg_len;
    logic                   tf_w, tf_h;

    assign in_fire = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign b       = s_data.data_byte;

    // A start-of-file byte is parsed against freshly cleared state.
    always_comb begin
        if (s_data.start_of_file) begin
            cur_phase  = ihds_pkg::PH_MAGIC;
            cur_magic  = '0;
            cur_skip   = '0;
            cur_accum  = '0;
            cur_fbi    = '0;
            cur_be     = 1'b0;
            cur_left   = '0;
            cur_tag    = '0;
            cur_short  = 1'b0;
            cur_width  = '0;
            cur_height = '0;
            cur_wknown = 1'b0;
            cur_hknown = 1'b0;
            cur_done   = 1'b0;
        end else begin
            cur_phase  = phase_reg;
            cur_magic  = magic_reg;
            cur_skip   = skip_reg;
            cur_accum  = accum_reg;
            cur_fbi    = fbi_reg;
            cur_be     = be_reg;
            cur_left   = left_reg;
            cur_tag    = tag_reg;
            cur_short  = short_reg;
            cur_width  = width_reg;
            cur_height = height_reg;
            cur_wknown = wknown_reg;
            cur_hknown = hknown_reg;
            cur_done   = done_reg;
        end
    end

    // Field gathering shared by every multi-byte field after the signature.
    always_comb begin
        acc_base = (cur_fbi == 3'd0) ? 32'd0 : cur_accum;
        if (cur_be) begin
            acc_take = {acc_base[23:0], b};
        end else begin
            acc_take = acc_base | ({24'd0, b} << {cur_fbi[1:0], 3'b000});
        end
        fbi_inc   = cur_fbi + 3'd1;
        got2      = (fbi_inc >= 3'd2);
        got4      = (fbi_inc >= 3'd4);
        val_short = cur_short;
        got_val   = val_short ? got2 : got4;
        left_dec  = cur_left - 16'd1;
        ifd       = acc_take[OFFSET_BITS-1:0];
        seg_len   = acc_take[15:0];
        tf_w      = (cur_tag == ihds_pkg::TIFF_TAG_W);
        tf_h      = (cur_tag == ihds_pkg::TIFF_TAG_H);
    end

    always_comb begin
        phase_next  = cur_phase;
        magic_next  = cur_magic;
        skip_next   = cur_skip;
        accum_next  = cur_accum;
        fbi_next    = cur_fbi;
        be_next     = cur_be;
        left_next   = cur_left;
        tag_next    = cur_tag;
        short_next  = cur_short;
        width_next  = cur_width;
        height_next = cur_height;
        wknown_next = cur_wknown;
        hknown_next = cur_hknown;
        done_next   = cur_done;
        emit        = 1'b0;
        emit_data   = '{format: ihds_pkg::FMT_NONE, image_width: 32'd0, image_height: 32'd0};

        if (!cur_done) begin
            if (cur_skip != '0) begin
                skip_next = cur_skip - OFFSET_BITS'(1);
            end else begin
                unique case (cur_phase)
                    ihds_pkg::PH_MAGIC: begin
                        magic_next = {cur_magic[23:0], b};
                        fbi_next   = fbi_inc;
                        if (fbi_inc == 3'd3) begin
                            if (magic_next[23:16] == ihds_pkg::CH_G &&
                                magic_next[15:8] == ihds_pkg::CH_I &&
                                magic_next[7:0] == ihds_pkg::CH_F) begin
                                phase_next = ihds_pkg::PH_GIF_W;
                                skip_next  = OFFSET_BITS'(ihds_pkg::GIF_PAD);
                                be_next    = 1'b0;
                                fbi_next   = 3'd0;
                            end else if (magic_next[23:16] == ihds_pkg::JPEG_PREFIX &&
                                         magic_next[15:8] == ihds_pkg::JPEG_SOI) begin
                                phase_next = (magic_next[7:0] == ihds_pkg::JPEG_PREFIX) ?
                                             ihds_pkg::PH_JP_MARK : ihds_pkg::PH_FAIL;
                                skip_next  = '0;
                                be_next    = 1'b1;
                                fbi_next   = 3'd0;
                            end else if (magic_next[23:16] == ihds_pkg::PNG_SIG0 &&
                                         magic_next[15:8] == ihds_pkg::CH_P &&
                                         magic_next[7:0] == ihds_pkg::CH_N) begin
                                phase_next = ihds_pkg::PH_PNG_W;
                                skip_next  = OFFSET_BITS'(ihds_pkg::PNG_BMP_PAD);
                                be_next    = 1'b1;
                                fbi_next   = 3'd0;
                            end else if (magic_next[23:16] == ihds_pkg::CH_B &&
                                         magic_next[15:8] == ihds_pkg::CH_M) begin
                                phase_next = ihds_pkg::PH_BMP_W;
                                skip_next  = OFFSET_BITS'(ihds_pkg::PNG_BMP_PAD);
                                be_next    = 1'b0;
                                fbi_next   = 3'd0;
                            end
                        end else if (fbi_inc >= 3'd4) begin
                            skip_next = '0;
                            fbi_next  = 3'd0;
                            if (magic_next == ihds_pkg::TIFF_MAGIC_BE) begin
                                phase_next = ihds_pkg::PH_TF_IFD;
                                be_next    = 1'b1;
                            end else if (magic_next == ihds_pkg::TIFF_MAGIC_LE) begin
                                phase_next = ihds_pkg::PH_TF_IFD;
                                be_next    = 1'b0;
                            end else begin
                                phase_next = ihds_pkg::PH_FAIL;
                                be_next    = 1'b0;
                            end
                        end
                    end
                    ihds_pkg::PH_GIF_W, ihds_pkg::PH_PNG_W, ihds_pkg::PH_BMP_W: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            width_next  = acc_take;
                            wknown_next = 1'b1;
                            if (cur_phase == ihds_pkg::PH_GIF_W) begin
                                phase_next = ihds_pkg::PH_GIF_H;
                                skip_next  = '0;
                            end else if (cur_phase == ihds_pkg::PH_PNG_W) begin
                                phase_next = ihds_pkg::PH_PNG_H;
                                skip_next  = OFFSET_BITS'(2);
                            end else begin
                                phase_next = ihds_pkg::PH_BMP_H;
                                skip_next  = OFFSET_BITS'(2);
                            end
                        end
                    end
                    ihds_pkg::PH_GIF_H, ihds_pkg::PH_PNG_H, ihds_pkg::PH_BMP_H: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            height_next = acc_take;
                            hknown_next = 1'b1;
                            emit        = 1'b1;
                            emit_data.image_width  = cur_width;
                            emit_data.image_height = acc_take;
                            if (cur_phase == ihds_pkg::PH_GIF_H) begin
                                emit_data.format = ihds_pkg::FMT_GIF;
                            end else if (cur_phase == ihds_pkg::PH_PNG_H) begin
                                emit_data.format = ihds_pkg::FMT_PNG;
                            end else begin
                                emit_data.format = ihds_pkg::FMT_BMP;
                            end
                        end
                    end
                    ihds_pkg::PH_JP_MARK: begin
                        tag_next   = {8'd0, b};
                        phase_next = ihds_pkg::PH_JP_LEN;
                    end
                    ihds_pkg::PH_JP_LEN: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            be_next = 1'b1;
                            if (cur_tag == ihds_pkg::JPEG_SOF0 ||
                                cur_tag == ihds_pkg::JPEG_SOF1 ||
                                cur_tag == ihds_pkg::JPEG_SOF2) begin
                                phase_next = ihds_pkg::PH_JP_H;
                                skip_next  = OFFSET_BITS'(1);
                            end else begin
                                // The length counts its own two bytes.
                                phase_next = ihds_pkg::PH_JP_PREFIX;
                                skip_next  = (seg_len >= 16'd2) ?
                                             OFFSET_BITS'(seg_len - 16'd2) : '0;
                            end
                        end
                    end
                    ihds_pkg::PH_JP_H: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            height_next = acc_take;
                            hknown_next = 1'b1;
                            phase_next  = ihds_pkg::PH_JP_W;
                        end
                    end
                    ihds_pkg::PH_JP_W: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            width_next  = acc_take;
                            wknown_next = 1'b1;
                            emit        = 1'b1;
                            emit_data.format       = ihds_pkg::FMT_JPEG;
                            emit_data.image_width  = acc_take;
                            emit_data.image_height = cur_height;
                        end
                    end
                    ihds_pkg::PH_JP_PREFIX: begin
                        phase_next = (b == ihds_pkg::JPEG_PREFIX) ?
                                     ihds_pkg::PH_JP_MARK : ihds_pkg::PH_FAIL;
                    end
                    ihds_pkg::PH_TF_IFD: begin
                        accum_next = acc_take;
                        fbi_next   = got4 ? 3'd0 : fbi_inc;
                        if (got4) begin
                            // The offset counts from file start; the header is behind us.
                            phase_next = ihds_pkg::PH_TF_COUNT;
                            skip_next  = (ifd >= OFFSET_BITS'(ihds_pkg::TIFF_HDR_LEN)) ?
                                         ifd - OFFSET_BITS'(ihds_pkg::TIFF_HDR_LEN) : '0;
                        end
                    end
                    ihds_pkg::PH_TF_COUNT: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            left_next  = acc_take[15:0];
                            phase_next = (acc_take[15:0] == 16'd0) ?
                                         ihds_pkg::PH_FAIL : ihds_pkg::PH_TF_TAG;
                        end
                    end
                    ihds_pkg::PH_TF_TAG: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            tag_next   = acc_take[15:0];
                            phase_next = ihds_pkg::PH_TF_TYPE;
                        end
                    end
                    ihds_pkg::PH_TF_TYPE: begin
                        accum_next = acc_take;
                        fbi_next   = got2 ? 3'd0 : fbi_inc;
                        if (got2) begin
                            short_next = (acc_take[15:0] == ihds_pkg::TIFF_SHORT) ||
                                         (acc_take[15:0] == ihds_pkg::TIFF_SSHORT);
                            // Step over the four-byte count field.
                            skip_next  = OFFSET_BITS'(4);
                            phase_next = ihds_pkg::PH_TF_VAL;
                        end
                    end
                    ihds_pkg::PH_TF_VAL: begin
                        accum_next = acc_take;
                        fbi_next   = got_val ? 3'd0 : fbi_inc;
                        if (got_val) begin
                            if (tf_w) begin
                                width_next  = acc_take;
                                wknown_next = 1'b1;
                            end else if (tf_h) begin
                                height_next = acc_take;
                                hknown_next = 1'b1;
                            end
                            if (wknown_next && hknown_next) begin
                                emit = 1'b1;
                                emit_data.format       = ihds_pkg::FMT_TIFF;
                                emit_data.image_width  = width_next;
                                emit_data.image_height = height_next;
                            end else begin
                                left_next  = left_dec;
                                skip_next  = val_short ? OFFSET_BITS'(2) : '0;
                                phase_next = (left_dec == 16'd0) ?
                                             ihds_pkg::PH_FAIL : ihds_pkg::PH_TF_TAG;
                            end
                        end
                    end
                    ihds_pkg::PH_FAIL: begin
                    end
                    default: begin
                    end
                endcase
            end

            if (!emit && s_data.end_of_file) begin
                emit      = 1'b1;
                emit_data = '{format: ihds_pkg::FMT_NONE, image_width: 32'd0,
                              image_height: 32'd0};
            end
            if (emit) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= ihds_pkg::PH_MAGIC;
            magic_reg  <= '0;
            skip_reg   <= '0;
            accum_reg  <= '0;
            fbi_reg    <= '0;
            be_reg     <= 1'b0;
            left_reg   <= '0;
            tag_reg    <= '0;
            short_reg  <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            wknown_reg <= 1'b0;
            hknown_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            magic_reg  <= magic_next;
            skip_reg   <= skip_next;
            accum_reg  <= accum_next;
            fbi_reg    <= fbi_next;
            be_reg     <= be_next;
            left_reg   <= left_next;
            tag_reg    <= tag_next;
            short_reg  <= short_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            wknown_reg <= wknown_next;
            hknown_reg <= hknown_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && emit) begin
            m_data_reg <= emit_data;
        end
    end

`ifndef ASSERT_OFF
    a_eof_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_data.end_of_file) |=> done_reg)
        else $error("end-of-file transaction did not finish the file");

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && done_reg && !s_data.start_of_file) |-> !emit)
        else $error("second result for one file");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.format == ihds_pkg::FMT_NONE) |->
        (m_data.image_width == 32'd0 && m_data.image_height == 32'd0))
        else $error("unsupported result with nonzero dimensions");

    a_skip_holds_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !done_reg && !s_data.start_of_file && skip_reg != '0) |=>
        $stable(phase_reg))
        else $error("phase changed while skipping bytes");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the image header dimension sniffer. Whole files
// of GIF, PNG, BMP, JPEG and TIFF bytes are streamed in. Their content is
// random, and some files are damaged, cut short or plain noise. A byte-level
// predictor runs on every accepted input transaction, and each result
// transaction is compared with the oldest predicted format and size.
// Random idle cycles are applied on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int OFFSET_BITS   = 32;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [15:0] TIFF_LONG = 16'd4;

    typedef struct {
        ihds_pkg::in_t item;
        bit            hold;
    } feed_t;

    logic           aclk;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    ihds_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    ihds_pkg::out_t m_data;

    feed_t          byte_feed[$];
    ihds_pkg::out_t owed_reports[$];
    logic [7:0]     fbuf[$];
    int unsigned    reports_owed = 0;
    int unsigned    feed_gap     = 0;
    int unsigned    stall_left   = 0;
    int unsigned    cycle_cnt    = 0;
    int unsigned    mismatch_cnt = 0;
    bit             calm         = 1'b0;

    // Predictor state.
    ihds_pkg::phase_t ph;
    logic [31:0]      magic;
    logic [31:0]      skip_left;
    logic [31:0]      accum;
    logic [2:0]       byte_idx;
    bit               big_end;
    logic [15:0]      entries_left;
    logic [15:0]      tag;
    logic [15:0]      etype;
    logic [31:0]      width_v;
    logic [31:0]      height_v;
    bit               w_known;
    bit               h_known;
    bit               finished;

    image_header_dimension_sniffer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        ph           = ihds_pkg::PH_MAGIC;
        magic        = '0;
        skip_left    = '0;
        accum        = '0;
        byte_idx     = '0;
        big_end      = 1'b0;
        entries_left = '0;
        tag          = '0;
        etype        = '0;
        width_v      = '0;
        height_v     = '0;
        w_known      = 1'b0;
        h_known      = 1'b0;
        finished     = 1'b0;
    endfunction

    function automatic void jump(input ihds_pkg::phase_t p, input logic [31:0] skip,
                                 input bit be);
        ph        = p;
        skip_left = skip;
        big_end   = be;
        byte_idx  = '0;
    endfunction

    // Collects one byte of an n-byte field; true once the field is whole.
    function automatic bit gather(input logic [7:0] b, input int n);
        if (byte_idx == 3'd0) accum = '0;
        if (big_end) accum = {accum[23:0], b};
        else accum = accum | ({24'd0, b} << (8 * byte_idx[1:0]));
        byte_idx = byte_idx + 3'd1;
        if (byte_idx >= n) begin
            byte_idx = 3'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit post(input ihds_pkg::fmt_t f, input logic [31:0] w,
                                input logic [31:0] h);
        ihds_pkg::out_t r;
        r.format       = f;
        r.image_width  = w;
        r.image_height = h;
        owed_reports.push_back(r);
        finished = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b);
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
        logic [31:0] ifd;
        bit          shortv;
        case (ph)
            ihds_pkg::PH_MAGIC: begin
                magic    = {magic[23:0], b};
                byte_idx = byte_idx + 3'd1;
                c1 = magic[23:16];
                c2 = magic[15:8];
                c3 = magic[7:0];
                if (byte_idx == 3'd3) begin
                    if (c1 == ihds_pkg::CH_G && c2 == ihds_pkg::CH_I && c3 == ihds_pkg::CH_F)
                        jump(ihds_pkg::PH_GIF_W, ihds_pkg::GIF_PAD, 1'b0);
                    else if (c1 == ihds_pkg::JPEG_PREFIX && c2 == ihds_pkg::JPEG_SOI)
                        jump(c3 == ihds_pkg::JPEG_PREFIX ? ihds_pkg::PH_JP_MARK :
                             ihds_pkg::PH_FAIL, 0, 1'b1);
                    else if (c1 == ihds_pkg::PNG_SIG0 && c2 == ihds_pkg::CH_P &&
                             c3 == ihds_pkg::CH_N)
                        jump(ihds_pkg::PH_PNG_W, ihds_pkg::PNG_BMP_PAD, 1'b1);
                    else if (c1 == ihds_pkg::CH_B && c2 == ihds_pkg::CH_M)
                        jump(ihds_pkg::PH_BMP_W, ihds_pkg::PNG_BMP_PAD, 1'b0);
                end else if (byte_idx >= 3'd4) begin
                    // Only TIFF needs all four signature bytes.
                    if (magic == ihds_pkg::TIFF_MAGIC_BE)
                        jump(ihds_pkg::PH_TF_IFD, 0, 1'b1);
                    else if (magic == ihds_pkg::TIFF_MAGIC_LE)
                        jump(ihds_pkg::PH_TF_IFD, 0, 1'b0);
                    else
                        jump(ihds_pkg::PH_FAIL, 0, 1'b0);
                end
            end
            ihds_pkg::PH_GIF_W, ihds_pkg::PH_PNG_W, ihds_pkg::PH_BMP_W: begin
                if (gather(b, 2)) begin
                    width_v = accum;
                    w_known = 1'b1;
                    case (ph)
                        ihds_pkg::PH_GIF_W: ph = ihds_pkg::PH_GIF_H;
                        ihds_pkg::PH_PNG_W: begin
                            ph        = ihds_pkg::PH_PNG_H;
                            skip_left = 2;
                        end
                        default: begin
                            ph        = ihds_pkg::PH_BMP_H;
                            skip_left = 2;
                        end
                    endcase
                end
            end
            ihds_pkg::PH_GIF_H, ihds_pkg::PH_PNG_H, ihds_pkg::PH_BMP_H: begin
                if (gather(b, 2)) begin
                    height_v = accum;
                    h_known  = 1'b1;
                    return post(ph == ihds_pkg::PH_GIF_H ? ihds_pkg::FMT_GIF :
                                ph == ihds_pkg::PH_PNG_H ? ihds_pkg::FMT_PNG :
                                ihds_pkg::FMT_BMP, width_v, height_v);
                end
            end
            ihds_pkg::PH_JP_MARK: begin
                tag = {8'd0, b};
                ph  = ihds_pkg::PH_JP_LEN;
            end
            ihds_pkg::PH_JP_LEN: begin
                if (gather(b, 2)) begin
                    if (tag == ihds_pkg::JPEG_SOF0 || tag == ihds_pkg::JPEG_SOF1 ||
                        tag == ihds_pkg::JPEG_SOF2)
                        jump(ihds_pkg::PH_JP_H, 1, 1'b1);
                    else
                        jump(ihds_pkg::PH_JP_PREFIX, accum >= 2 ? accum - 2 : 0, 1'b1);
                end
            end
            ihds_pkg::PH_JP_H: begin
                if (gather(b, 2)) begin
                    height_v = accum;
                    h_known  = 1'b1;
                    ph       = ihds_pkg::PH_JP_W;
                end
            end
            ihds_pkg::PH_JP_W: begin
                if (gather(b, 2)) begin
                    width_v = accum;
                    w_known = 1'b1;
                    return post(ihds_pkg::FMT_JPEG, width_v, height_v);
                end
            end
            ihds_pkg::PH_JP_PREFIX:
                ph = (b == ihds_pkg::JPEG_PREFIX) ? ihds_pkg::PH_JP_MARK : ihds_pkg::PH_FAIL;
            ihds_pkg::PH_TF_IFD: begin
                if (gather(b, 4)) begin
                    ifd       = 32'(64'(accum) & ((64'd1 << OFFSET_BITS) - 64'd1));
                    ph        = ihds_pkg::PH_TF_COUNT;
                    skip_left = ifd >= ihds_pkg::TIFF_HDR_LEN ?
                                ifd - ihds_pkg::TIFF_HDR_LEN : 0;
                end
            end
            ihds_pkg::PH_TF_COUNT: begin
                if (gather(b, 2)) begin
                    entries_left = accum[15:0];
                    ph = entries_left == 0 ? ihds_pkg::PH_FAIL : ihds_pkg::PH_TF_TAG;
                end
            end
            ihds_pkg::PH_TF_TAG: begin
                if (gather(b, 2)) begin
                    tag = accum[15:0];
                    ph  = ihds_pkg::PH_TF_TYPE;
                end
            end
            ihds_pkg::PH_TF_TYPE: begin
                if (gather(b, 2)) begin
                    etype     = accum[15:0];
                    skip_left = 4;
                    ph        = ihds_pkg::PH_TF_VAL;
                end
            end
            ihds_pkg::PH_TF_VAL: begin
                shortv = etype == ihds_pkg::TIFF_SHORT || etype == ihds_pkg::TIFF_SSHORT;
                if (gather(b, shortv ? 2 : 4)) begin
                    if (tag == ihds_pkg::TIFF_TAG_W) begin
                        width_v = accum;
                        w_known = 1'b1;
                    end else if (tag == ihds_pkg::TIFF_TAG_H) begin
                        height_v = accum;
                        h_known  = 1'b1;
                    end
                    if (w_known && h_known)
                        return post(ihds_pkg::FMT_TIFF, width_v, height_v);
                    entries_left = entries_left - 16'd1;
                    skip_left    = shortv ? 2 : 0;
                    ph           = entries_left == 0 ? ihds_pkg::PH_FAIL :
                                   ihds_pkg::PH_TF_TAG;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void sniff_byte(input ihds_pkg::in_t it);
        bit got;
        if (it.start_of_file) clear_parse();
        if (finished) return;
        got = 1'b0;
        if (skip_left != 0) skip_left = skip_left - 1;
        else got = parse_byte(it.data_byte);
        if (!got && it.end_of_file) void'(post(ihds_pkg::FMT_NONE, '0, '0));
    endfunction

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic void put8(input logic [7:0] b);
        fbuf.push_back(b);
    endfunction

    function automatic void put16(input logic [15:0] v, input bit be);
        if (be) begin
            put8(v[15:8]);
            put8(v[7:0]);
        end else begin
            put8(v[7:0]);
            put8(v[15:8]);
        end
    endfunction

    function automatic void put32(input logic [31:0] v, input bit be);
        if (be) begin
            put16(v[31:16], 1'b1);
            put16(v[15:0], 1'b1);
        end else begin
            put16(v[15:0], 1'b0);
            put16(v[31:16], 1'b0);
        end
    endfunction

    function automatic void put_rand(input int n);
        for (int i = 0; i < n; i++) put8(8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_long();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void build_jpeg();
        logic [7:0] marker;
        int         len;
        put8(ihds_pkg::JPEG_PREFIX);
        put8(ihds_pkg::JPEG_SOI);
        put8(ihds_pkg::JPEG_PREFIX);
        repeat ($urandom_range(0, 3)) begin
            marker = 8'($urandom_range(0, 255));
            if (marker >= ihds_pkg::JPEG_SOF0 && marker <= ihds_pkg::JPEG_SOF2)
                marker = 8'hE0;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(0, 1);
                1: len = $urandom_range(11, 60);
                default: len = $urandom_range(2, 10);
            endcase
            put8(marker);
            put16(len[15:0], 1'b1);
            put_rand(len > 2 ? len - 2 : 0);
            put8(ihds_pkg::JPEG_PREFIX);
        end
        put8(8'(ihds_pkg::JPEG_SOF0 + $urandom_range(0, 2)));
        put16(16'($urandom_range(0, 65535)), 1'b1);
        put8(8'($urandom_range(0, 255)));
        put16(pick_dim(), 1'b1);
        put16(pick_dim(), 1'b1);
    endfunction

    function automatic void build_tiff();
        bit          be;
        logic [31:0] offs;
        logic [15:0] etag;
        logic [15:0] etyp;
        int          n;
        int          wpos;
        int          hpos;
        be = 1'($urandom_range(0, 1));
        put32(be ? ihds_pkg::TIFF_MAGIC_BE : ihds_pkg::TIFF_MAGIC_LE, 1'b1);
        case ($urandom_range(0, 19))
            0, 1, 2: offs = $urandom_range(0, 7);
            3:       offs = $urandom | 32'h0001_0000;
            4, 5:    offs = $urandom_range(15, 48);
            default: offs = 8 + $urandom_range(0, 6);
        endcase
        put32(offs, be);
        // An offset far past the file leaves nothing but the end of file.
        if (offs > 32'h0000_FFFF) begin
            put_rand(4);
            return;
        end
        put_rand(offs >= 8 ? offs - 8 : 0);
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        put16(n[15:0], be);
        if (n == 0) return;
        wpos = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, n - 1);
        hpos = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, n - 1);
        if (hpos == wpos && n > 1) hpos = (wpos + 1) % n;
        for (int e = 0; e < n; e++) begin
            if (e == wpos) etag = ihds_pkg::TIFF_TAG_W;
            else if (e == hpos) etag = ihds_pkg::TIFF_TAG_H;
            else if ($urandom_range(0, 7) == 0) etag = 16'($urandom_range(256, 257));
            else etag = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 7))
                0, 1:    etyp = ihds_pkg::TIFF_SHORT;
                2:       etyp = ihds_pkg::TIFF_SSHORT;
                3:       etyp = 16'($urandom_range(0, 65535));
                default: etyp = TIFF_LONG;
            endcase
            put16(etag, be);
            put16(etyp, be);
            put_rand(4);
            if (etyp == ihds_pkg::TIFF_SHORT || etyp == ihds_pkg::TIFF_SSHORT) begin
                put16(pick_dim(), be);
                put_rand(2);
            end else begin
                put32(pick_long(), be);
            end
        end
    endfunction

    function automatic void build_file(input int kind);
        case (kind)
            0: begin
                put8(ihds_pkg::CH_G);
                put8(ihds_pkg::CH_I);
                put8(ihds_pkg::CH_F);
                put_rand(3);
                put16(pick_dim(), 1'b0);
                put16(pick_dim(), 1'b0);
            end
            1: begin
                put8(ihds_pkg::PNG_SIG0);
                put8(ihds_pkg::CH_P);
                put8(ihds_pkg::CH_N);
                put_rand(15);
                put16(pick_dim(), 1'b1);
                put_rand(2);
                put16(pick_dim(), 1'b1);
            end
            2: begin
                put8(ihds_pkg::CH_B);
                put8(ihds_pkg::CH_M);
                put_rand(16);
                put16(pick_dim(), 1'b0);
                put_rand(2);
                put16(pick_dim(), 1'b0);
            end
            3, 4:    build_jpeg();
            5, 6, 7: build_tiff();
            default: put_rand($urandom_range(1, 8));
        endcase
    endfunction

    // Turns the file buffer into input transactions and empties it.
    function automatic void queue_file(input bit sof, input bit eof, input bit hold,
                                       input bit noisy);
        feed_t f;
        for (int i = 0; i < fbuf.size(); i++) begin
            f.item.data_byte     = fbuf[i];
            f.item.start_of_file = sof && i == 0;
            f.item.end_of_file   = (eof && i == fbuf.size() - 1) ||
                                   (noisy && $urandom_range(0, 299) == 0);
            f.hold = hold && i == 0;
            byte_feed.push_back(f);
        end
        fbuf.delete();
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver, sink and checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            feed_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (feed_gap != 0) begin
                feed_gap <= feed_gap - 1;
                s_valid  <= 1'b0;
            end else if (byte_feed.size() == 0) begin
                s_valid <= 1'b0;
            end else if (byte_feed[0].hold && (s_valid || reports_owed != 0 || m_valid)) begin
                // Drain every outstanding result before this file starts.
                s_valid <= 1'b0;
            end else begin
                s_data  <= byte_feed[0].item;
                s_valid <= 1'b1;
                byte_feed.delete(0);
                feed_gap <= pick_gap();
                if ($urandom_range(0, 149) == 0) calm <= !calm;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report(input string msg);
        if (mismatch_cnt < 100) $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    // Outputs are checked before the input transaction of the same edge is
    // predicted; a result can never come out in the cycle its byte goes in.
    always @(posedge aclk) begin
        ihds_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (owed_reports.size() == 0) begin
                    report("result transaction with nothing expected");
                end else begin
                    want = owed_reports.pop_front();
                    if (m_data.format !== want.format)
                        report($sformatf("format %0d, expected %0d",
                                         m_data.format, want.format));
                    if (m_data.image_width !== want.image_width)
                        report($sformatf("width %0d, expected %0d",
                                         m_data.image_width, want.image_width));
                    if (m_data.image_height !== want.image_height)
                        report($sformatf("height %0d, expected %0d",
                                         m_data.image_height, want.image_height));
                end
            end
            if (s_valid && s_ready) sniff_byte(s_data);
            reports_owed <= owed_reports.size();
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int target;
        int kind;
        int files;
        int pos;
        clear_parse();

        // GIF with both dimensions at their largest.
        fbuf = '{ihds_pkg::CH_G, ihds_pkg::CH_I, ihds_pkg::CH_F, 8'h38, 8'h39, 8'h61,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        queue_file(1'b1, 1'b1, 1'b0, 1'b0);
        // A one-byte file cannot be identified.
        fbuf = '{8'h00};
        queue_file(1'b1, 1'b1, 1'b0, 1'b0);
        // JPEG segment length of one skips nothing; the next byte is then
        // a bad marker prefix.
        fbuf = '{ihds_pkg::JPEG_PREFIX, ihds_pkg::JPEG_SOI, ihds_pkg::JPEG_PREFIX,
                 8'hE0, 8'h00, 8'h01, 8'h7E};
        queue_file(1'b1, 1'b1, 1'b0, 1'b0);
        // Little-endian TIFF, IFD offset below the header, no entries.
        fbuf = '{ihds_pkg::CH_I, ihds_pkg::CH_I, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00};
        queue_file(1'b1, 1'b1, 1'b0, 1'b0);

        target = byte_feed.size() + RANDOM_ITEMS;
        files  = 0;
        while (byte_feed.size() < target) begin
            kind = $urandom_range(0, 9);
            build_file(kind == 9 ? $urandom_range(0, 7) : kind);
            if (kind == 9) begin
                // Near miss: one flipped bit within the first four bytes of the file.
                pos = $urandom_range(0, (fbuf.size() < 4 ? fbuf.size() : 4) - 1);
                fbuf[pos] = fbuf[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
            case ($urandom_range(0, 19))
                0, 1: begin
                    pos = $urandom_range(1, fbuf.size());
                    while (fbuf.size() > pos) fbuf.delete(fbuf.size() - 1);
                end
                2:       fbuf[$urandom_range(0, fbuf.size() - 1)] = 8'($urandom_range(0, 255));
                3, 4:    put_rand($urandom_range(1, 4));
                default: ;
            endcase
            queue_file($urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0,
                       files == 0 || $urandom_range(0, 39) == 0, 1'b1);
            files++;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_feed.size() != 0 || s_valid) @(negedge aclk);
        while (owed_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
